// ----- hdl/owsm_pkg.sv -----
// Shared types and constants of the octave window spectrum smoother.
package owsm_pkg;

  localparam int BIN_W   = 11;
  localparam int DATA_W  = 16;
  localparam int SPREAD_W = 16;
  localparam int COUNT_W = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  // window bounds: (2047 * 65535 >> 8) + 1 fits in 20 bits
  localparam int HI_W    = 20;
  localparam int FRAC_W  = 8;

  typedef enum logic {
    KIND_STORE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPREAD    = 1'b0,
    REG_BIN_COUNT = 1'b1
  } reg_idx_t;

  localparam logic [SPREAD_W-1:0] SPREAD_RESET    = 16'd256;
  localparam logic [COUNT_W-1:0]  BIN_COUNT_RESET = 12'd1025;

endpackage

// ----- hdl/owsm_in_if.sv -----
// Input item channel: store or query request.
interface owsm_in_if;
  logic                               valid;
  logic                               ready;
  owsm_pkg::kind_t                    kind;
  logic [owsm_pkg::BIN_W-1:0]         bin_index;
  logic signed [owsm_pkg::DATA_W-1:0] mag_db;

  modport source (output valid, kind, bin_index, mag_db, input ready);
  modport sink   (input valid, kind, bin_index, mag_db, output ready);
endinterface

// ----- hdl/owsm_out_if.sv -----
// Result item channel: smoothed magnitude of one queried bin.
interface owsm_out_if;
  logic                               valid;
  logic                               ready;
  logic [owsm_pkg::BIN_W-1:0]         bin_echo;
  logic signed [owsm_pkg::DATA_W-1:0] smoothed_db;

  modport source (output valid, bin_echo, smoothed_db, input ready);
  modport sink   (input valid, bin_echo, smoothed_db, output ready);
endinterface

// ----- hdl/octave_window_spectrum_smoother.sv -----
// Smoothed dB spectrum over a frequency-scaled window. A store item writes one
// bin. A query item for bin i uses the one shared restoring divider, of width
// DW = max(19, 17 + log2(MAX_BINS)): the divider forms lo = floor(256*i/s),
// then the window of n = hi - lo bins (at most MAX_BINS - 1) is summed reading
// one bin per cycle through the RAM port, then the divider forms the truncated
// mean. An empty window skips the sum and the second division. No item is taken
// while a query is under way; a finished result waits in the output register
// while the next item is taken, and a query that finishes while that register
// is still held waits until it is taken.
// No clearing pass at reset.
module octave_window_spectrum_smoother #(
  parameter int MAX_BINS = 2048
) (
  input  logic                              clk,
  input  logic                              rst_n,
  owsm_in_if.sink                           in_ch,
  owsm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [owsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [owsm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW  = $clog2(MAX_BINS);
  localparam int LW  = AW + 1;
  localparam int SW  = owsm_pkg::DATA_W + AW + 1;
  localparam int DW  = (SW > owsm_pkg::HI_W - 1) ? SW : owsm_pkg::HI_W - 1;
  localparam int VW  = (AW + 1 > owsm_pkg::SPREAD_W) ? AW + 1 : owsm_pkg::SPREAD_W;
  localparam int CTW = $clog2(DW + 1);
  localparam int HW  = owsm_pkg::HI_W;
  localparam int PW  = owsm_pkg::BIN_W + owsm_pkg::SPREAD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO_DIV,
    ST_BOUNDS,
    ST_SUM,
    ST_MEAN_DIV,
    ST_FINISH
  } state_t;

  state_t                              state_r, state_nxt;
  logic [owsm_pkg::SPREAD_W-1:0]       spread_r, spread_nxt;
  logic [owsm_pkg::COUNT_W-1:0]        count_r, count_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [owsm_pkg::BIN_W-1:0]          out_bin_r, out_bin_nxt;
  logic [owsm_pkg::DATA_W-1:0]         out_db_r, out_db_nxt;
  logic [owsm_pkg::BIN_W-1:0]          bin_r, bin_nxt;
  logic [HW-1:0]                       hi_r, hi_nxt;
  logic [DW-1:0]                       div_num_r, div_num_nxt;
  logic [VW-1:0]                       div_den_r, div_den_nxt;
  logic [VW-1:0]                       div_rem_r, div_rem_nxt;
  logic [CTW-1:0]                      div_cnt_r, div_cnt_nxt;
  logic [AW-1:0]                       addr_r, addr_nxt;
  logic [LW-1:0]                       issue_left_r, issue_left_nxt;
  logic [LW-1:0]                       len_r, len_nxt;
  logic                                rd_vld_r, rd_vld_nxt;
  logic signed [SW-1:0]                sum_r, sum_nxt;
  logic                                neg_r, neg_nxt;
  logic [owsm_pkg::DATA_W-1:0]         res_r, res_nxt;

  logic                                in_acc;
  logic [owsm_pkg::SPREAD_W-1:0]       spread_eff;
  logic [PW-1:0]                       prod;
  logic [owsm_pkg::COUNT_W-1:0]        cnt_eff;
  logic [HW-1:0]                       lim, lo, hi_c;
  logic                                empty;
  logic [VW:0]                         rem_sh, den_x, rem_sub;
  logic                                ge;
  logic [SW-1:0]                       sum_mag;
  logic [DW-1:0]                       quot;
  logic                                ram_we;
  logic [AW-1:0]                       ram_addr;
  logic [owsm_pkg::DATA_W-1:0]         ram_rdata;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.bin_echo    = out_bin_r;
  assign out_ch.smoothed_db = out_db_r;

  // zero spread acts as the smallest spread
  assign spread_eff = (spread_r == '0) ? owsm_pkg::SPREAD_W'(1) : spread_r;
  assign prod       = PW'(in_ch.bin_index) * PW'(spread_eff);

  assign cnt_eff = (int'({20'd0, count_r}) > MAX_BINS) ? owsm_pkg::COUNT_W'(MAX_BINS)
                                                       : count_r;
  assign lim   = HW'(cnt_eff) - HW'(1);
  assign lo    = HW'(div_num_r);
  assign hi_c  = (hi_r > lim) ? lim : hi_r;
  assign empty = (cnt_eff == '0) || (hi_c <= lo);

  // one restoring division step: one quotient bit per cycle
  assign rem_sh  = {div_rem_r, div_num_r[DW-1]};
  assign den_x   = {1'b0, div_den_r};
  assign ge      = (rem_sh >= den_x);
  assign rem_sub = rem_sh - den_x;

  assign sum_mag = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign quot    = {div_num_r[DW-2:0], ge};

  assign ram_we   = in_acc && (in_ch.kind == owsm_pkg::KIND_STORE) &&
                    (int'({21'd0, in_ch.bin_index}) < MAX_BINS);
  assign ram_addr = (state_r == ST_IDLE) ? AW'(in_ch.bin_index) : addr_r;

  owsm_ram #(
    .WIDTH (owsm_pkg::DATA_W),
    .DEPTH (MAX_BINS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_ch.mag_db),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    spread_nxt     = spread_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    out_bin_nxt    = out_bin_r;
    out_db_nxt     = out_db_r;
    bin_nxt        = bin_r;
    hi_nxt         = hi_r;
    div_num_nxt    = div_num_r;
    div_den_nxt    = div_den_r;
    div_rem_nxt    = div_rem_r;
    div_cnt_nxt    = div_cnt_r;
    addr_nxt       = addr_r;
    issue_left_nxt = issue_left_r;
    len_nxt        = len_r;
    rd_vld_nxt     = 1'b0;
    sum_nxt        = sum_r;
    neg_nxt        = neg_r;
    res_nxt        = res_r;

    if (cfg_we) begin
      case (cfg_index)
        owsm_pkg::REG_SPREAD:    spread_nxt = cfg_wdata;
        owsm_pkg::REG_BIN_COUNT: count_nxt  = owsm_pkg::COUNT_W'(cfg_wdata);
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.kind == owsm_pkg::KIND_QUERY)) begin
          bin_nxt     = in_ch.bin_index;
          hi_nxt      = HW'(prod >> owsm_pkg::FRAC_W) + HW'(1);
          div_num_nxt = DW'({in_ch.bin_index, {owsm_pkg::FRAC_W{1'b0}}});
          div_den_nxt = VW'(spread_eff);
          div_rem_nxt = '0;
          div_cnt_nxt = CTW'(DW);
          state_nxt   = ST_LO_DIV;
        end
      end
      ST_LO_DIV, ST_MEAN_DIV: begin
        div_num_nxt = quot;
        div_rem_nxt = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        div_cnt_nxt = div_cnt_r - CTW'(1);
        if (div_cnt_r == CTW'(1)) begin
          if (state_r == ST_LO_DIV) begin
            state_nxt = ST_BOUNDS;
          end else begin
            res_nxt   = owsm_pkg::DATA_W'(neg_r ? (~quot + DW'(1)) : quot);
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_BOUNDS: begin
        if (empty) begin
          res_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          addr_nxt       = AW'(lo);
          issue_left_nxt = LW'(hi_c - lo);
          len_nxt        = LW'(hi_c - lo);
          sum_nxt        = '0;
          state_nxt      = ST_SUM;
        end
      end
      ST_SUM: begin
        // read data shows up in the cycle after its address
        if (issue_left_r != '0) begin
          addr_nxt       = addr_r + AW'(1);
          issue_left_nxt = issue_left_r - LW'(1);
          rd_vld_nxt     = 1'b1;
        end
        if (rd_vld_r) begin
          sum_nxt = sum_r + SW'(signed'(ram_rdata));
        end
        if ((issue_left_r == '0) && !rd_vld_r) begin
          neg_nxt     = sum_r[SW-1];
          div_num_nxt = DW'(sum_mag);
          div_den_nxt = VW'(len_r);
          div_rem_nxt = '0;
          div_cnt_nxt = CTW'(DW);
          state_nxt   = ST_MEAN_DIV;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_bin_nxt   = bin_r;
          out_db_nxt    = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spread_r    <= owsm_pkg::SPREAD_RESET;
      count_r     <= owsm_pkg::BIN_COUNT_RESET;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spread_r    <= spread_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
    end
    out_bin_r    <= out_bin_nxt;
    out_db_r     <= out_db_nxt;
    bin_r        <= bin_nxt;
    hi_r         <= hi_nxt;
    div_num_r    <= div_num_nxt;
    div_den_r    <= div_den_nxt;
    div_rem_r    <= div_rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    addr_r       <= addr_nxt;
    issue_left_r <= issue_left_nxt;
    len_r        <= len_nxt;
    sum_r        <= sum_nxt;
    neg_r        <= neg_nxt;
    res_r        <= res_nxt;
  end

  a_rd_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SUM) && ($past(state_r) == ST_SUM))
    else $error("window read data outside the summing phase");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready) |=>
      out_valid_r && (state_r == ST_IDLE))
    else $error("finished query did not reach the output register");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> (issue_left_r <= len_r) && (len_r != '0))
    else $error("window read count out of range");

  a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE) && !rd_vld_r)
    else $error("store write while a query is under way");

endmodule

// ----- hdl/owsm_ram.sv -----
// Generic single-port RAM with registered read data.
module owsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- test/owsm_smoothing_checker.sv -----
// Checker for the spectrum smoother: tracks stored bins and registers, predicts each query.
module owsm_smoothing_checker #(
  parameter int MAX_BINS = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  owsm_in_if                              in_ch,
  owsm_out_if                             out_ch,
  input  logic                            cfg_we,
  input  logic [owsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              failures,
  output int                              answered
);

  typedef struct {
    logic [owsm_pkg::BIN_W-1:0]         bin;
    logic signed [owsm_pkg::DATA_W-1:0] db;
  } smoothed_t;

  logic signed [owsm_pkg::DATA_W-1:0] mag_store [MAX_BINS];
  logic [owsm_pkg::SPREAD_W-1:0]      spread;
  logic [owsm_pkg::COUNT_W-1:0]       bins_in_use;
  smoothed_t                          smoothed_due [$];
  int                                 mismatches;
  int                                 results_seen;

  // truncated mean of the stored bins in [lo, hi), zero for an empty window
  function automatic logic signed [owsm_pkg::DATA_W-1:0] window_mean_db(
    input logic [owsm_pkg::BIN_W-1:0] bin);
    longint s, used, lo, hi, acc, k;
    s    = (spread == '0) ? 1 : spread;
    used = (bins_in_use > MAX_BINS) ? MAX_BINS : bins_in_use;
    lo   = (longint'(bin) << owsm_pkg::FRAC_W) / s;
    hi   = ((longint'(bin) * s) >> owsm_pkg::FRAC_W) + 1;
    if (hi > used - 1) hi = used - 1;
    if (hi <= lo) return '0;
    acc = 0;
    for (k = lo; k < hi; k++) acc += mag_store[k];
    return owsm_pkg::DATA_W'(acc / (hi - lo));
  endfunction

  always @(posedge clk) begin
    smoothed_t got, want;
    if (!rst_n) begin
      spread = owsm_pkg::SPREAD_RESET;
      bins_in_use = owsm_pkg::BIN_COUNT_RESET;
      smoothed_due.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (owsm_pkg::reg_idx_t'(cfg_index))
          owsm_pkg::REG_SPREAD:    spread = cfg_wdata[owsm_pkg::SPREAD_W-1:0];
          owsm_pkg::REG_BIN_COUNT: bins_in_use = cfg_wdata[owsm_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got.bin = out_ch.bin_echo;
        got.db = out_ch.smoothed_db;
        results_seen++;
        if (smoothed_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: bin %0d smoothed %0d", got.bin, got.db);
        end else begin
          want = smoothed_due.pop_front();
          if (got.bin !== want.bin || got.db !== want.db) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected bin %0d smoothed %0d, got bin %0d smoothed %0d",
                       want.bin, want.db, got.bin, got.db);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.kind == owsm_pkg::KIND_STORE) begin
          if (in_ch.bin_index < MAX_BINS) mag_store[in_ch.bin_index] = in_ch.mag_db;
        end else begin
          want.bin = in_ch.bin_index;
          want.db = window_mean_db(in_ch.bin_index);
          smoothed_due.push_back(want);
        end
      end
    end
    // queries still unanswered count as failures once the run has drained
    failures <= mismatches + smoothed_due.size();
    answered <= results_seen;
  end

endmodule

// ----- test/tb_octave_window_spectrum_smoother.sv -----
// Testbench top for the spectrum smoother: clock, reset, stimulus, stalls and verdict.
module tb_octave_window_spectrum_smoother;

  localparam int MAX_BINS    = 2048;
  localparam int ITEM_TARGET = 265;
  localparam int SETTLE      = 2200;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [owsm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [owsm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                              failures;
  int                              answered;

  // no idling on either side while set
  bit                              calm;
  logic [owsm_pkg::SPREAD_W-1:0]   cur_spread;
  logic [owsm_pkg::COUNT_W-1:0]    cur_count;
  bit                              filled [MAX_BINS];
  int                              queries_sent;
  int                              stores_sent;
  int                              settings_used;

  owsm_in_if  in_ch ();
  owsm_out_if out_ch ();

  octave_window_spectrum_smoother #(.MAX_BINS(MAX_BINS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  owsm_smoothing_checker #(.MAX_BINS(MAX_BINS)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .answered  (answered)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #10000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [owsm_pkg::DATA_W-1:0] random_db();
    return owsm_pkg::DATA_W'($urandom);
  endfunction

  function automatic logic [owsm_pkg::BIN_W-1:0] pick_bin();
    int span;
    span = (cur_count > MAX_BINS) ? MAX_BINS : cur_count;
    if (span < 1 || $urandom_range(0, 9) < 4) return owsm_pkg::BIN_W'($urandom);
    return owsm_pkg::BIN_W'($urandom_range(0, span - 1));
  endfunction

  initial begin : result_stall
    int hold, stall;
    out_ch.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        stall = pick_gap();
        out_ch.ready <= (stall == 0);
        hold = (stall == 0) ? $urandom_range(0, 6) : stall - 1;
      end
    end
  end

  task automatic push_item(input owsm_pkg::kind_t kind, input logic [owsm_pkg::BIN_W-1:0] bin,
                           input logic signed [owsm_pkg::DATA_W-1:0] mag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.bin_index <= bin;
    in_ch.mag_db <= mag;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == owsm_pkg::KIND_QUERY) queries_sent++;
    else stores_sent++;
  endtask

  task automatic store_bin(input logic [owsm_pkg::BIN_W-1:0] bin,
                           input logic signed [owsm_pkg::DATA_W-1:0] mag);
    push_item(owsm_pkg::KIND_STORE, bin, mag);
    filled[bin] = 1'b1;
  endtask

  // a query may only cover bins that hold a value, so fill any hole first
  task automatic ask_bin(input logic [owsm_pkg::BIN_W-1:0] bin);
    longint s, used, lo, hi, k;
    s    = (cur_spread == '0) ? 1 : cur_spread;
    used = (cur_count > MAX_BINS) ? MAX_BINS : cur_count;
    lo   = (longint'(bin) << owsm_pkg::FRAC_W) / s;
    hi   = ((longint'(bin) * s) >> owsm_pkg::FRAC_W) + 1;
    if (hi > used - 1) hi = used - 1;
    for (k = lo; k < hi; k++)
      if (!filled[k]) store_bin(owsm_pkg::BIN_W'(k), random_db());
    push_item(owsm_pkg::KIND_QUERY, bin, random_db());
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (answered != queries_sent) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_config(input logic [owsm_pkg::SPREAD_W-1:0] spread,
                            input logic [owsm_pkg::COUNT_W-1:0] count);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= owsm_pkg::REG_SPREAD;
    cfg_wdata <= spread;
    @(posedge clk);
    cfg_index <= owsm_pkg::REG_BIN_COUNT;
    cfg_wdata <= owsm_pkg::CFG_DATA_W'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_spread = spread;
    cur_count = count;
    settings_used++;
  endtask

  initial begin : stimulus
    int r, n;
    logic [owsm_pkg::SPREAD_W-1:0] spread;
    logic [owsm_pkg::COUNT_W-1:0]  count;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind <= owsm_pkg::KIND_STORE;
    in_ch.bin_index <= '0;
    in_ch.mag_db <= '0;
    cfg_we <= 1'b0;
    cfg_index <= owsm_pkg::REG_SPREAD;
    cfg_wdata <= '0;
    cur_spread = owsm_pkg::SPREAD_RESET;
    cur_count = owsm_pkg::BIN_COUNT_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: single-bin windows, field extremes
    store_bin(11'd0, 16'sh7FFF);
    store_bin(11'd1, -16'sh8000);
    store_bin(11'd2, -16'sd1);
    store_bin(11'd2047, 16'sh5555);
    ask_bin(11'd0);
    ask_bin(11'd1);
    ask_bin(11'd2047);  // past bin_count: empty window
    ask_bin(11'd2);
    // spread 2.0: window 1..6
    set_config(16'd512, 12'd8);
    ask_bin(11'd3);
    // widest spread, window clipped by bin_count
    set_config(16'hFFFF, 12'd10);
    ask_bin(11'd9);
    // zero spread acts as the smallest spread
    set_config(16'd0, 12'd10);
    ask_bin(11'd5);
    ask_bin(11'd0);
    // zero and one bins in use: every window empty
    set_config(owsm_pkg::SPREAD_RESET, 12'd0);
    ask_bin(11'd0);
    set_config(owsm_pkg::SPREAD_RESET, 12'd1);
    ask_bin(11'd0);
    // count above the store size gets clamped; then a count of exactly the store size
    set_config(owsm_pkg::SPREAD_RESET, 12'hFFF);
    ask_bin(11'd2046);
    ask_bin(11'd2047);
    set_config(owsm_pkg::SPREAD_RESET, 12'd2048);
    ask_bin(11'd2046);

    while (stores_sent + queries_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 70) count = owsm_pkg::COUNT_W'($urandom_range(2, 80));
      else if (r < 80) count = owsm_pkg::COUNT_W'($urandom_range(81, 400));
      else if (r < 85) count = owsm_pkg::COUNT_W'($urandom_range(0, 1));
      else if (r < 92) count = 12'd2048;
      else count = owsm_pkg::COUNT_W'($urandom_range(2049, 4095));
      r = $urandom_range(0, 99);
      // large counts keep the spread at or below about one so windows stay short
      if (count > 400)
        spread = (r < 25) ? owsm_pkg::SPREAD_W'($urandom_range(0, 255))
                          : owsm_pkg::SPREAD_W'($urandom_range(240, 272));
      else if (r < 30) spread = owsm_pkg::SPREAD_RESET;
      else if (r < 65) spread = owsm_pkg::SPREAD_W'($urandom_range(257, 1024));
      else if (r < 80) spread = owsm_pkg::SPREAD_W'($urandom_range(0, 255));
      else spread = owsm_pkg::SPREAD_W'($urandom_range(1025, 65535));
      set_config(spread, count);
      calm = ($urandom_range(0, 4) == 0);
      n = $urandom_range(12, 36);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 6) drain();
        else if (r < 50) store_bin(pick_bin(), random_db());
        else ask_bin(pick_bin());
      end
    end

    calm = 1'b1;
    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Run sent %0d stores and %0d queries over %0d register settings.",
             stores_sent, queries_sent, settings_used);
    $display("Settings included zero and full-scale spread, zero, one, full and clamped counts.");
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/owsm_pkg.sv
hdl/owsm_in_if.sv
hdl/owsm_out_if.sv
hdl/owsm_ram.sv
hdl/octave_window_spectrum_smoother.sv
test/owsm_smoothing_checker.sv
test/tb_octave_window_spectrum_smoother.sv
